/* src/udrb_pkg.sv */
package udrb_pkg;

    // Function codes carried in the low bits of s_tuser.
    localparam logic [2:0] FN_RX_BYTE   = 3'd0;
    localparam logic [2:0] FN_TX_QUEUE  = 3'd1;
    localparam logic [2:0] FN_TX_DONE   = 3'd2;
    localparam logic [2:0] FN_HOST_READ = 3'd3;
    localparam logic [2:0] FN_CLEAR_RX  = 3'd4;
    localparam logic [2:0] FN_CLEAR_TX  = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_ROOM = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 3;

    typedef struct packed {
        logic [2:0] func;
        logic       port_index;
        logic [7:0] data_byte;
        logic       block_first;
        logic       block_last;
        logic [8:0] block_length;
        logic       port_ok;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic [7:0]  line_tx_byte;
        logic        line_tx_start;
        logic        drive_enable;
        logic [7:0]  rx_available;
        logic        tx_busy;
        logic [31:0] rx_overflows;
        logic [31:0] tx_overflows;
    } result_t;

endpackage

/* src/uart_dual_ring_buffer_with_driver_enable_unit.sv */
// Receive and transmit ring buffers for half-duplex serial ports with a
// driver-enable output per port.
// The s_ channel takes one item per request: a received line byte, a host
// byte to queue, a line transmit-done report, a host read, or a ring clear.
// Every accepted item yields exactly one item on the m_ channel with the
// status, any popped byte, any byte to start on the line, the driver-enable
// level and the port's ring and overflow counters.
// cfg_we/cfg_wdata set the driver-enable level that means transmit; write
// it only while no item is in progress.
// The back end updates the ring pointers and issues the ring memory access
// in its exec state, then, once the output is free, loads the registered
// memory data into the output register in its done state; it takes no new
// item from the queue until the last result has been loaded.
// A two-entry queue sits between the input decode and the ring engine, so
// while a result waits on m_tready up to three further items are taken (one
// held in the back end, two in the queue); then s_tready drops until the
// stalled result is taken and the back end pulls the next queued item.
// Reset empties all rings, clears the counters, sets every port to receive
// level and the polarity to active high. Ring contents are not cleared.
module uart_dual_ring_buffer_with_driver_enable_unit #(
    parameter int PORT_COUNT = 2,
    parameter int RX_DEPTH   = 256,
    parameter int TX_DEPTH   = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // data_byte[7:0], block_first[8], block_length[17:9], zero pad
    input  logic [udrb_pkg::IN_TDATA_W-1:0]    s_tdata,
    // func[2:0], port_index[3]
    input  logic [udrb_pkg::IN_TUSER_W-1:0]    s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // read_byte[7:0], read_valid[8], line_tx_byte[16:9], line_tx_start[17],
    // drive_enable[18], rx_available[26:19], tx_busy[27],
    // rx_overflows[59:28], tx_overflows[91:60], zero pad
    output logic [udrb_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // status[2:0]
    output logic [udrb_pkg::OUT_TUSER_W-1:0]   m_tuser
);
    import udrb_pkg::*;

    logic         polarity_reg;
    logic         push;
    item_t        push_item;
    item_t        head;
    queue_flags_t flags;
    logic         pop;
    result_t      res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polarity_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            polarity_reg <= cfg_wdata;
        end
    end

    udrb_front #(
        .PORT_COUNT(PORT_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .flags    (flags),
        .push     (push),
        .push_item(push_item)
    );

    udrb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .head     (head),
        .flags    (flags)
    );

    udrb_back #(
        .PORT_COUNT(PORT_COUNT),
        .RX_DEPTH  (RX_DEPTH),
        .TX_DEPTH  (TX_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .polarity (polarity_reg),
        .head     (head),
        .flags    (flags),
        .pop      (pop),
        .out_data (res),
        .out_valid(m_tvalid),
        .out_ready(m_tready)
    );

    assign m_tdata = {4'b0, res.tx_overflows, res.rx_overflows, res.tx_busy,
                      res.rx_available, res.drive_enable, res.line_tx_start,
                      res.line_tx_byte, res.read_valid, res.read_byte};
    assign m_tuser = res.status;

endmodule

/* src/udrb_queue.sv */
module udrb_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  udrb_pkg::item_t        push_item,
    input  logic                   pop,
    output udrb_pkg::item_t        head,
    output udrb_pkg::queue_flags_t flags
);
    import udrb_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head        = slot_reg[rd_ptr_reg];
    assign flags.full  = (count_reg == 2'd2);
    assign flags.empty = (count_reg == 2'd0);

endmodule

/* src/udrb_front.sv */
module udrb_front #(
    parameter int PORT_COUNT = 2
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [udrb_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic [udrb_pkg::IN_TUSER_W-1:0] s_tuser,
    input  logic                          s_tlast,
    input  udrb_pkg::queue_flags_t        flags,
    output logic                          push,
    output udrb_pkg::item_t               push_item
);
    import udrb_pkg::*;

    localparam logic UPPER_PORT_OK = (PORT_COUNT > 1);

    assign s_tready = !flags.full;
    assign push     = s_tvalid && !flags.full;

    always_comb
    begin
        push_item.func         = s_tuser[2:0];
        push_item.port_index   = s_tuser[3];
        push_item.data_byte    = s_tdata[7:0];
        push_item.block_first  = s_tdata[8];
        push_item.block_last   = s_tlast;
        push_item.block_length = s_tdata[17:9];
        // Items for a port that is not built are marked here and skipped by the back end.
        push_item.port_ok      = !s_tuser[3] || UPPER_PORT_OK;
    end

endmodule

/* src/udrb_back.sv */
module udrb_back #(
    parameter int PORT_COUNT = 2,
    parameter int RX_DEPTH   = 256,
    parameter int TX_DEPTH   = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   polarity,
    input  udrb_pkg::item_t        head,
    input  udrb_pkg::queue_flags_t flags,
    output logic                   pop,
    output udrb_pkg::result_t      out_data,
    output logic                   out_valid,
    input  logic                   out_ready
);
    import udrb_pkg::*;

    localparam int PORT_W   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_CW    = RX_PTR_W + 1;
    localparam int TX_CW    = TX_PTR_W + 1;
    localparam int AV_W     = (RX_CW > 8) ? RX_CW : 8;
    localparam int CMP_W    = (TX_CW > 9) ? TX_CW : 9;
    localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);

    localparam logic S_EXEC = 1'b0;
    localparam logic S_DONE = 1'b1;

    logic state_reg;
    logic state_next;

    logic [RX_PTR_W-1:0] rx_wp_reg  [PORT_COUNT];
    logic [RX_PTR_W-1:0] rx_rp_reg  [PORT_COUNT];
    logic [TX_PTR_W-1:0] tx_wp_reg  [PORT_COUNT];
    logic [TX_PTR_W-1:0] tx_rp_reg  [PORT_COUNT];
    logic                flight_reg [PORT_COUNT];
    logic                accept_reg [PORT_COUNT];
    logic                dir_reg    [PORT_COUNT];
    logic [31:0]         drop_reg   [PORT_COUNT];
    logic [31:0]         refuse_reg [PORT_COUNT];

    logic [7:0] rx_mem [PORT_COUNT][RX_DEPTH];
    logic [7:0] tx_mem [PORT_COUNT][TX_DEPTH];
    logic [7:0] rx_rd_reg;
    logic [7:0] tx_rd_reg;
    logic       fwd_reg;
    logic [7:0] fwd_data_reg;

    result_t pend_reg;
    result_t pend_next;
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;

    logic [PORT_W-1:0]   p;
    logic                exec_go;
    logic                upd;
    logic [RX_PTR_W-1:0] rx_wp;
    logic [RX_PTR_W-1:0] rx_rp;
    logic [TX_PTR_W-1:0] tx_wp;
    logic [TX_PTR_W-1:0] tx_rp;
    logic [RX_PTR_W-1:0] rx_wp_adv;
    logic [RX_PTR_W-1:0] rx_rp_adv;
    logic [TX_PTR_W-1:0] tx_wp_adv;
    logic [TX_PTR_W-1:0] tx_rp_adv;
    logic [RX_PTR_W-1:0] rx_wp_n;
    logic [RX_PTR_W-1:0] rx_rp_n;
    logic [TX_PTR_W-1:0] tx_wp_n;
    logic [TX_PTR_W-1:0] tx_rp_n;
    logic                flight_n;
    logic                accept_n;
    logic                dir_n;
    logic [31:0]         drop_n;
    logic [31:0]         refuse_n;
    logic                acc;
    logic                kick_req;
    logic                flight_eff;
    logic                rx_we;
    logic                rx_re;
    logic                tx_we;
    logic                tx_re;
    logic [2:0]          status;
    logic                rvalid;
    logic [TX_CW-1:0]    tx_used;
    logic [CMP_W-1:0]    tx_free;
    logic [RX_CW-1:0]    rx_used;
    logic [AV_W-1:0]     avail_wide;
    logic                out_free;

    assign p        = PORT_W'(head.port_index);
    assign exec_go  = (state_reg == S_EXEC) && !flags.empty;
    assign pop      = exec_go;
    assign upd      = exec_go && head.port_ok;
    assign out_free = !out_valid_reg || out_ready;

    assign rx_wp = rx_wp_reg[p];
    assign rx_rp = rx_rp_reg[p];
    assign tx_wp = tx_wp_reg[p];
    assign tx_rp = tx_rp_reg[p];

    assign rx_wp_adv = (rx_wp == RX_LAST) ? '0 : rx_wp + RX_PTR_W'(1);
    assign rx_rp_adv = (rx_rp == RX_LAST) ? '0 : rx_rp + RX_PTR_W'(1);
    assign tx_wp_adv = (tx_wp == TX_LAST) ? '0 : tx_wp + TX_PTR_W'(1);
    assign tx_rp_adv = (tx_rp == TX_LAST) ? '0 : tx_rp + TX_PTR_W'(1);

    // Free transmit space before this item writes anything.
    assign tx_used = (tx_wp >= tx_rp) ? (TX_CW'(tx_wp) - TX_CW'(tx_rp))
                                      : (TX_CW'(TX_DEPTH) - TX_CW'(tx_rp) + TX_CW'(tx_wp));
    assign tx_free = CMP_W'(TX_DEPTH - 1) - CMP_W'(tx_used);

    always_comb
    begin
        rx_wp_n    = rx_wp;
        rx_rp_n    = rx_rp;
        tx_wp_n    = tx_wp;
        tx_rp_n    = tx_rp;
        flight_n   = flight_reg[p];
        accept_n   = accept_reg[p];
        dir_n      = dir_reg[p];
        drop_n     = drop_reg[p];
        refuse_n   = refuse_reg[p];
        acc        = accept_reg[p];
        kick_req   = 1'b0;
        flight_eff = flight_reg[p];
        rx_we      = 1'b0;
        rx_re      = 1'b0;
        tx_we      = 1'b0;
        tx_re      = 1'b0;
        status     = ST_OK;
        rvalid     = 1'b0;

        unique case (head.func)
            FN_RX_BYTE:
            begin
                if (rx_wp_adv != rx_rp)
                begin
                    rx_we   = 1'b1;
                    rx_wp_n = rx_wp_adv;
                end
                else
                begin
                    drop_n = drop_reg[p] + 32'd1;
                    status = ST_DROPPED;
                end
            end
            FN_TX_QUEUE:
            begin
                if (head.block_first)
                begin
                    acc = 1'b0;
                    if (head.block_length == 9'd0)
                    begin
                        status = ST_INVALID;
                    end
                    else if (tx_free < CMP_W'(head.block_length))
                    begin
                        refuse_n = refuse_reg[p] + 32'd1;
                        status   = ST_NO_ROOM;
                    end
                    else
                    begin
                        acc = 1'b1;
                    end
                end
                else if (!acc)
                begin
                    status = ST_NO_ROOM;
                end
                if (acc)
                begin
                    if (tx_wp_adv != tx_rp)
                    begin
                        tx_we   = 1'b1;
                        tx_wp_n = tx_wp_adv;
                    end
                    else
                    begin
                        status = ST_NO_ROOM;
                    end
                    kick_req = head.block_last;
                end
                accept_n = acc && !head.block_last;
            end
            FN_TX_DONE:
            begin
                flight_eff = 1'b0;
                flight_n   = 1'b0;
                kick_req   = 1'b1;
            end
            FN_HOST_READ:
            begin
                if (rx_wp == rx_rp)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    rx_re   = 1'b1;
                    rvalid  = 1'b1;
                    rx_rp_n = rx_rp_adv;
                end
            end
            FN_CLEAR_RX:
            begin
                rx_wp_n = '0;
                rx_rp_n = '0;
            end
            FN_CLEAR_TX:
            begin
                tx_wp_n = '0;
                tx_rp_n = '0;
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase

        // Start the next line byte once the line is idle; an empty ring drops the driver.
        if (kick_req && !flight_eff)
        begin
            if (tx_wp_n == tx_rp)
            begin
                dir_n = 1'b0;
            end
            else
            begin
                tx_re    = 1'b1;
                tx_rp_n  = tx_rp_adv;
                dir_n    = 1'b1;
                flight_n = 1'b1;
            end
        end
    end

    assign rx_used    = (rx_wp_n >= rx_rp_n) ? (RX_CW'(rx_wp_n) - RX_CW'(rx_rp_n))
                        : (RX_CW'(RX_DEPTH) - RX_CW'(rx_rp_n) + RX_CW'(rx_wp_n));
    assign avail_wide = AV_W'(rx_used);

    always_comb
    begin
        pend_next = '0;
        if (head.port_ok)
        begin
            pend_next.status        = status;
            pend_next.read_valid    = rvalid;
            pend_next.line_tx_start = tx_re;
            pend_next.drive_enable  = dir_n ? polarity : ~polarity;
            pend_next.rx_available  = (avail_wide > AV_W'(255)) ? 8'hFF : avail_wide[7:0];
            pend_next.tx_busy       = flight_n || (tx_wp_n != tx_rp_n);
            pend_next.rx_overflows  = drop_n;
            pend_next.tx_overflows  = refuse_n;
        end
        else
        begin
            pend_next.status = ST_INVALID;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_EXEC;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EXEC;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                rx_wp_reg[i]  <= '0;
                rx_rp_reg[i]  <= '0;
                tx_wp_reg[i]  <= '0;
                tx_rp_reg[i]  <= '0;
                flight_reg[i] <= 1'b0;
                accept_reg[i] <= 1'b0;
                dir_reg[i]    <= 1'b0;
                drop_reg[i]   <= 32'd0;
                refuse_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (upd)
            begin
                rx_wp_reg[p]  <= rx_wp_n;
                rx_rp_reg[p]  <= rx_rp_n;
                tx_wp_reg[p]  <= tx_wp_n;
                tx_rp_reg[p]  <= tx_rp_n;
                flight_reg[p] <= flight_n;
                accept_reg[p] <= accept_n;
                dir_reg[p]    <= dir_n;
                drop_reg[p]   <= drop_n;
                refuse_reg[p] <= refuse_n;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd && rx_we)
        begin
            rx_mem[p][rx_wp] <= head.data_byte;
        end
        if (upd && rx_re)
        begin
            rx_rd_reg <= rx_mem[p][rx_rp];
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd && tx_we)
        begin
            tx_mem[p][tx_wp] <= head.data_byte;
        end
        if (upd && tx_re)
        begin
            tx_rd_reg <= tx_mem[p][tx_rp];
        end
    end

    always_comb
    begin
        out_next              = pend_reg;
        out_next.read_byte    = pend_reg.read_valid ? rx_rd_reg : 8'd0;
        out_next.line_tx_byte = pend_reg.line_tx_start
                                ? (fwd_reg ? fwd_data_reg : tx_rd_reg) : 8'd0;
    end

    // A byte written and started by the same item bypasses the memory read.
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            pend_reg     <= pend_next;
            fwd_reg      <= tx_we && (tx_wp == tx_rp);
            fwd_data_reg <= head.data_byte;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

/* src/udrb_checker.sv */
module udrb_port_assertions (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [udrb_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [udrb_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import udrb_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A popped byte only comes with a good status, otherwise the byte field is zero.
    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[8] ? (m_tuser == ST_OK) : (m_tdata[7:0] == 8'd0)))
        else $error("read byte inconsistent with status");

    // Starting a line byte leaves the transmitter busy.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[17] |-> m_tdata[27])
        else $error("line start without busy");

    // A read of an empty ring reports nothing available.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[26:19] == 8'd0) && !m_tdata[8])
        else $error("empty status with bytes available");

endmodule

bind uart_dual_ring_buffer_with_driver_enable_unit udrb_port_assertions u_udrb_port_assertions (.*);
